### sv/tccs_pkg.sv
// Shared constants, command and result types for the text console engine.
`default_nettype none
package tccs_pkg;

    localparam int COLUMNS = 80;
    localparam int CELLS   = 2000;

    localparam int CUR_W  = 11;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int DATA_W = 16;

    localparam logic [DATA_W-1:0] BLANK_WORD   = 16'h0720;
    localparam logic [7:0]        DEFAULT_ATTR = 8'h07;
    localparam logic [7:0]        SPACE_CODE   = 8'h20;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_PUT,
        CMD_BS,
        CMD_NL,
        CMD_CR,
        CMD_TAB
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [DATA_W-1:0]  word;
        logic [ADDR_W-1:0]  addr;
        logic               addr_ok;
    } cmd_t;

    typedef struct packed {
        logic [CUR_W-1:0]  cursor_position;
        logic [DATA_W-1:0] read_data;
        logic              scrolled;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_TAB,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL
    } state_t;

endpackage
`default_nettype wire

### sv/text_console_cursor_scroll.sv
// Top level of the text console engine: front end, command queue, executor.
//
// Items enter through a two-entry command queue and leave through a two-entry
// result queue. After reset the screen store is cleared to blanks in a single pass,
// during which full stays high. In the executor a read uses a registered read
// of the screen memory, and a tab writes blanks from the cursor on. A scroll
// uses one memory write port to move each cell up a row, then blanks the last
// row. Sustained rate is one item per cycle for non-scrolling puts while the
// result queue is not full.
`default_nettype none
module text_console_cursor_scroll (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         op,
    input  wire logic [7:0]   character,
    input  wire logic [7:0]   attribute,
    input  wire logic [10:0]  cell_address,
    output logic              empty,
    input  wire logic         pop,
    output logic [10:0]       cursor_position,
    output logic [15:0]       read_data,
    output logic              scrolled
);
    import tccs_pkg::*;

    logic  clearing;
    logic  cmd_valid;
    logic  cmd_pop;
    cmd_t  cmd;
    logic  res_valid;
    res_t  res;

    tccs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .op           (op),
        .character    (character),
        .attribute    (attribute),
        .cell_address (cell_address),
        .clearing     (clearing),
        .cmd_pop      (cmd_pop),
        .full         (full),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    tccs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty           = !res_valid;
    assign cursor_position = res.cursor_position;
    assign read_data       = res.read_data;
    assign scrolled        = res.scrolled;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cursor_position < 11'(CELLS)))
        else $error("cursor beyond screen");

    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && scrolled) |-> (read_data == 16'h0000))
        else $error("scroll result carries read data");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (full && !cmd_pop))
        else $error("item taken during clearing pass");

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("executor popped empty command queue");

endmodule
`default_nettype wire

### sv/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### sv/tccs_front.sv
// Front end: accepts items, classifies them into commands and queues them.
`default_nettype none
module tccs_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic         op,
    input  wire logic [7:0]   character,
    input  wire logic [7:0]   attribute,
    input  wire logic [10:0]  cell_address,
    input  wire logic         clearing,
    input  wire logic         cmd_pop,
    output logic              full,
    output logic              cmd_valid,
    output tccs_pkg::cmd_t    cmd
);
    import tccs_pkg::*;

    cmd_t        q_mem [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        accept;
    logic        do_pop;
    logic [7:0]  attr_eff;
    cmd_t        cmd_in;

    always_comb
    begin
        attr_eff = (attribute == 8'd0) ? DEFAULT_ATTR : attribute;
        cmd_in.addr    = cell_address[ADDR_W-1:0];
        cmd_in.addr_ok = (cell_address < 11'(CELLS));
        cmd_in.word    = {attr_eff, character};
        if (op)
        begin
            cmd_in.kind = CMD_READ;
        end
        else
        begin
            case (character)
                CH_BS:
                begin
                    cmd_in.kind = CMD_BS;
                    cmd_in.word = {attr_eff, SPACE_CODE};
                end
                CH_TAB:  cmd_in.kind = CMD_TAB;
                CH_NL:   cmd_in.kind = CMD_NL;
                CH_CR:   cmd_in.kind = CMD_CR;
                default: cmd_in.kind = CMD_PUT;
            endcase
        end
    end

    assign full      = (count_reg == 2'd2) || clearing;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (accept && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

### sv/tccs_back.sv
// Back end: executes commands on the screen store and cursor, queues results.
`default_nettype none
module tccs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire tccs_pkg::cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 clearing,
    input  wire logic            res_pop,
    output logic                 res_valid,
    output tccs_pkg::res_t       res
);
    import tccs_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CUR_W-1:0]    cur_reg;
    logic [CUR_W-1:0]    cur_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   idx_next;
    logic [1:0]          tab_cnt_reg;
    logic [1:0]          tab_cnt_next;
    logic                tab_more_reg;
    logic                tab_more_next;
    logic                scr_reg;
    logic                scr_next;
    logic                pend_reg;
    logic                pend_next;
    logic [ADDR_W-1:0]   pwaddr_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                res_push;
    res_t                res_in;
    res_t                rq_mem [2];
    logic                rq_wptr_reg;
    logic                rq_rptr_reg;
    logic [1:0]          rq_count_reg;
    logic                res_full;
    logic                do_res_pop;

    logic [CUR_W-1:0]    cur_inc;
    logic [COL_W-1:0]    col_inc;
    logic [COL_W-1:0]    col_dec;
    logic [CUR_W-1:0]    cur_row;
    logic [CUR_W-1:0]    cur_nl;

    tccs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_inc  = cur_reg + CUR_W'(1);
    assign col_inc  = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
    assign col_dec  = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
    assign cur_row  = cur_reg - CUR_W'(col_reg);
    assign cur_nl   = cur_row + CUR_W'(COLUMNS);
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        col_next      = col_reg;
        idx_next      = idx_reg;
        tab_cnt_next  = tab_cnt_reg;
        tab_more_next = tab_more_reg;
        scr_next      = scr_reg;
        pend_next     = 1'b0;
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg[ADDR_W-1:0];
        ram_wdata     = BLANK_WORD;
        ram_re        = 1'b0;
        ram_raddr     = cmd.addr;
        res_push      = 1'b0;
        res_in.cursor_position = cur_reg;
        res_in.read_data       = '0;
        res_in.scrolled        = 1'b0;

        // copy write lands in the cycle after its read
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pwaddr_reg;
            ram_wdata = ram_rdata;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = BLANK_WORD;
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop       = 1'b1;
                    tab_more_next = 1'b0;
                    case (cmd.kind)
                        CMD_READ:
                        begin
                            if (cmd.addr_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_READ_WAIT;
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                        CMD_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = cmd.word;
                            cur_next  = cur_inc;
                            col_next  = col_inc;
                            if (cur_inc == CUR_W'(CELLS))
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                res_push               = 1'b1;
                                res_in.cursor_position = cur_inc;
                            end
                        end
                        CMD_BS:
                        begin
                            res_push = 1'b1;
                            if (cur_reg != '0)
                            begin
                                cur_next               = cur_reg - CUR_W'(1);
                                col_next               = col_dec;
                                ram_we                 = 1'b1;
                                ram_waddr              = cur_next[ADDR_W-1:0];
                                ram_wdata              = cmd.word;
                                res_in.cursor_position = cur_next;
                            end
                        end
                        CMD_NL:
                        begin
                            cur_next = cur_nl;
                            col_next = '0;
                            if (cur_nl == CUR_W'(CELLS))
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                res_push               = 1'b1;
                                res_in.cursor_position = cur_nl;
                            end
                        end
                        CMD_CR:
                        begin
                            cur_next               = cur_row;
                            col_next               = '0;
                            res_push               = 1'b1;
                            res_in.cursor_position = cur_row;
                        end
                        CMD_TAB:
                        begin
                            tab_cnt_next = 2'd0;
                            scr_next     = 1'b0;
                            state_next   = ST_TAB;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                res_push         = 1'b1;
                res_in.read_data = ram_rdata;
                state_next       = ST_IDLE;
            end
            ST_TAB:
            begin
                ram_we       = 1'b1;
                ram_wdata    = BLANK_WORD;
                cur_next     = cur_inc;
                col_next     = col_inc;
                tab_cnt_next = tab_cnt_reg + 2'd1;
                if (cur_inc == CUR_W'(CELLS))
                begin
                    tab_more_next = (tab_cnt_reg != 2'd3);
                    scr_next      = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_SCROLL_COPY;
                end
                else if (tab_cnt_reg == 2'd3)
                begin
                    res_push               = 1'b1;
                    res_in.cursor_position = cur_inc;
                    res_in.scrolled        = scr_reg;
                    state_next             = ST_IDLE;
                end
            end
            ST_SCROLL_COPY:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg + ADDR_W'(COLUMNS);
                pend_next = 1'b1;
                idx_next  = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(CELLS - COLUMNS - 1))
                begin
                    state_next = ST_SCROLL_FILL;
                end
            end
            ST_SCROLL_FILL:
            begin
                if (!pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = BLANK_WORD;
                    idx_next  = idx_reg + ADDR_W'(1);
                    if (idx_reg == ADDR_W'(CELLS - 1))
                    begin
                        idx_next = '0;
                        cur_next = cur_reg - CUR_W'(COLUMNS);
                        if (tab_more_reg)
                        begin
                            state_next = ST_TAB;
                        end
                        else
                        begin
                            res_push               = 1'b1;
                            res_in.cursor_position = cur_next;
                            res_in.scrolled        = 1'b1;
                            state_next             = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cur_reg      <= '0;
            col_reg      <= '0;
            idx_reg      <= '0;
            tab_cnt_reg  <= '0;
            tab_more_reg <= 1'b0;
            scr_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            col_reg      <= col_next;
            idx_reg      <= idx_next;
            tab_cnt_reg  <= tab_cnt_next;
            tab_more_reg <= tab_more_next;
            scr_reg      <= scr_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pwaddr_reg <= idx_reg;
    end

    // result queue, two entries
    assign res_full   = (rq_count_reg == 2'd2);
    assign res_valid  = (rq_count_reg != 2'd0);
    assign do_res_pop = res_pop && res_valid;
    assign res        = rq_mem[rq_rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wptr_reg  <= 1'b0;
            rq_rptr_reg  <= 1'b0;
            rq_count_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                rq_wptr_reg <= !rq_wptr_reg;
            end
            if (do_res_pop)
            begin
                rq_rptr_reg <= !rq_rptr_reg;
            end
            if (res_push && !do_res_pop)
            begin
                rq_count_reg <= rq_count_reg + 2'd1;
            end
            else if (!res_push && do_res_pop)
            begin
                rq_count_reg <= rq_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rq_mem[rq_wptr_reg] <= res_in;
        end
    end

endmodule
`default_nettype wire
